// ----- hdl/ptw_pkg.sv -----
// shared constants and types for the phase period tracker with loss watchdog
package ptw_pkg;

  // field widths
  localparam int TS_W     = 32;              // timer and millisecond timestamps
  localparam int PH_SEL_W = 2;               // phase_select / result_phase
  localparam int PER_W    = 40;              // filtered period, Q32.8
  localparam int ALPHA_W  = 17;              // ema weight, Q1.16
  localparam int ANGLE_W  = 13;              // angles in 1/16 degree
  localparam int TMO_W    = 16;              // loss timeout in ms
  localparam int LOSS_W   = 3;               // loss flags on the result
  localparam int CFG_W    = 17;              // widest configuration register
  localparam int CFG_A_W  = 2;               // configuration register index

  // ema accumulator: 41-bit partial sum above the 17 multiplier bits
  localparam int EMA_W    = PER_W + ALPHA_W + 1;
  localparam int EMA_SUM_W = EMA_W - ALPHA_W + 1;
  // angle products and the divide by 5760 * 256 = 45 * 2^15
  localparam int PROD_W   = PER_W + ANGLE_W;
  localparam int DIV_SH   = 15;
  localparam int DIVD_W   = PROD_W - DIV_SH;
  localparam int DIV_K    = 45;
  localparam int REM_W    = 6;

  // step counter covers the longest serial pass
  localparam int CNT_W    = 6;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 112;

  // parameter defaults
  localparam int NUM_PHASES_DEF = 3;

  // unity weight and reset values of the registers
  localparam logic [ALPHA_W-1:0] ALPHA_ONE       = ALPHA_W'(65536);
  localparam logic [ALPHA_W-1:0] ALPHA_RST       = ALPHA_W'(6554);
  localparam logic [ANGLE_W-1:0] PHASING_RST     = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0] PULSE_RST       = ANGLE_W'(160);
  localparam logic [TMO_W-1:0]   TIMEOUT_RST     = TMO_W'(40);

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_EMA_ALPHA     = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_PHASING_ANGLE = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_PULSE_ANGLE   = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_LOSS_TIMEOUT  = 2'd3;

  // command codes
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EMA  = 6'b000010,
    S_ANG  = 6'b000100,
    S_DIV  = 6'b001000,
    S_TICK = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

endpackage

// ----- hdl/phase_period_tracker_watchdog.sv -----
// three-phase period tracker: serial ema filter, angle scaling and loss watchdog
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-----------------------------------------------
//  in      | in  | tvalid / tready  | tuser: command; tdata: phase, capture, now_ms
//  out     | out | tvalid / tready  | tdata: phase, period, zero time, pulse, loss
//  cfg     | in  | we               | addr selects register, wdata is the value
//
// a capture: accept, 17 ema steps (one alpha bit each), 13 angle multiply steps
// (one angle bit each), 38 divide steps (one quotient bit each), finish. a tick:
// accept, watchdog check, finish; a capture out of phase range: accept, finish.
// synchronous active-low reset clears all but the payload registers, no clearing
// pass. the result register frees the input side: a new item is taken while the
// last result waits; only a finished item blocks on a stalled output.
module phase_period_tracker_watchdog #(
  parameter int NUM_PHASES = ptw_pkg::NUM_PHASES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ptw_pkg::IN_DATA_W-1:0]  in_tdata,   // phase_select, capture_time, now_ms
  input  logic                           in_tuser,   // command
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ptw_pkg::OUT_DATA_W-1:0] out_tdata,  // result_phase, period_avg,
                                                     // zero_time, pulse_ticks, loss_flags
  // configuration writes
  input  logic                           cfg_we,
  input  logic [ptw_pkg::CFG_A_W-1:0]    cfg_addr,
  input  logic [ptw_pkg::CFG_W-1:0]      cfg_wdata
);

  import ptw_pkg::*;

  localparam int PH_W = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
  localparam int LX_W = (NUM_PHASES > LOSS_W) ? NUM_PHASES : LOSS_W;

  // configuration registers
  logic [ALPHA_W-1:0] alpha_r;
  logic [ANGLE_W-1:0] phasing_r;
  logic [ANGLE_W-1:0] pulse_r;
  logic [TMO_W-1:0]   timeout_r;

  // per-phase state
  logic [TS_W-1:0]        prev_cap_r [NUM_PHASES];
  logic [TS_W-1:0]        prev_cap_nxt [NUM_PHASES];
  logic [PER_W-1:0]       filt_r [NUM_PHASES];
  logic [PER_W-1:0]       filt_nxt [NUM_PHASES];
  logic [TS_W-1:0]        seen_r [NUM_PHASES];
  logic [TS_W-1:0]        seen_nxt [NUM_PHASES];
  logic [NUM_PHASES-1:0]  lost_r, lost_nxt;

  // sequencer
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cap_ok_r, cap_ok_nxt;

  // latched item
  logic [PH_SEL_W-1:0] ph_r, ph_nxt;
  logic [TS_W-1:0]     cap_r, cap_nxt;
  logic [TS_W-1:0]     now_r, now_nxt;

  // serial datapath
  logic [PER_W-1:0]   x_r, x_nxt;       // raw period, Q32.8
  logic [PER_W-1:0]   f_r, f_nxt;       // old filtered period
  logic [ALPHA_W-1:0] bm_r, bm_nxt;     // 1 - alpha, shifted out lsb first
  logic [EMA_W-1:0]   ema_r, ema_nxt;
  logic [PER_W-1:0]   nf_r, nf_nxt;
  logic [PROD_W-1:0]  pz_r, pz_nxt, pp_r, pp_nxt;
  logic [DIVD_W-1:0]  qz_r, qz_nxt, qp_r, qp_nxt;
  logic [REM_W-1:0]   rz_r, rz_nxt, rp_r, rp_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // input field views
  logic [PH_SEL_W-1:0] in_ph;
  logic [TS_W-1:0]     in_cap;
  logic [TS_W-1:0]     in_now;
  logic [PH_W-1:0]     in_idx;
  logic [PH_W-1:0]     idx;
  logic                in_xfer;

  // step results
  logic [ALPHA_W-1:0]   alpha_sat;
  logic [EMA_SUM_W-1:0] ema_sum;
  logic [EMA_W-1:0]     ema_step;
  logic [PER_W:0]       pz_sum, pp_sum;
  logic [PROD_W-1:0]    pz_step, pp_step;
  logic [REM_W:0]       rz_t, rp_t;
  logic                 rz_ge, rp_ge;
  logic [LX_W-1:0]      lost_ext;
  logic [TS_W-1:0]      zero_time;
  logic [TS_W-1:0]      pulse_ticks;

  assign in_ph   = in_tdata[PH_SEL_W-1:0];
  assign in_cap  = in_tdata[PH_SEL_W +: TS_W];
  assign in_now  = in_tdata[PH_SEL_W+TS_W +: TS_W];
  assign in_idx  = PH_W'(in_ph);
  assign idx     = PH_W'(ph_r);

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // weight clamped to one; its complement is taken when a capture is accepted
  assign alpha_sat = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

  // ema step: add raw and old period under one bit of alpha and 1 - alpha
  assign ema_sum  = EMA_SUM_W'(ema_r[EMA_W-1:ALPHA_W])
                  + (ema_r[0] ? EMA_SUM_W'(x_r) : EMA_SUM_W'(0))
                  + (bm_r[0]  ? EMA_SUM_W'(f_r) : EMA_SUM_W'(0));
  assign ema_step = {ema_sum, ema_r[ALPHA_W-1:1]};

  // angle multiply steps
  assign pz_sum  = (PER_W+1)'(pz_r[PROD_W-1:ANGLE_W])
                 + (pz_r[0] ? (PER_W+1)'(nf_r) : (PER_W+1)'(0));
  assign pp_sum  = (PER_W+1)'(pp_r[PROD_W-1:ANGLE_W])
                 + (pp_r[0] ? (PER_W+1)'(nf_r) : (PER_W+1)'(0));
  assign pz_step = {pz_sum, pz_r[ANGLE_W-1:1]};
  assign pp_step = {pp_sum, pp_r[ANGLE_W-1:1]};

  // restoring divide by 45, one quotient bit per step
  assign rz_t  = {rz_r, qz_r[DIVD_W-1]};
  assign rp_t  = {rp_r, qp_r[DIVD_W-1]};
  assign rz_ge = (rz_t >= (REM_W+1)'(DIV_K));
  assign rp_ge = (rp_t >= (REM_W+1)'(DIV_K));

  // result fields
  assign lost_ext    = LX_W'(lost_r);
  assign zero_time   = cap_r + qz_r[TS_W-1:0];
  assign pulse_ticks = (|qp_r[DIVD_W-1:TS_W]) ? '1 : qp_r[TS_W-1:0];

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cap_ok_nxt    = cap_ok_r;
    ph_nxt        = ph_r;
    cap_nxt       = cap_r;
    now_nxt       = now_r;
    x_nxt         = x_r;
    f_nxt         = f_r;
    bm_nxt        = bm_r;
    ema_nxt       = ema_r;
    nf_nxt        = nf_r;
    pz_nxt        = pz_r;
    pp_nxt        = pp_r;
    qz_nxt        = qz_r;
    qp_nxt        = qp_r;
    rz_nxt        = rz_r;
    rp_nxt        = rp_r;
    prev_cap_nxt  = prev_cap_r;
    filt_nxt      = filt_r;
    seen_nxt      = seen_r;
    lost_nxt      = lost_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          ph_nxt  = in_ph;
          cap_nxt = in_cap;
          now_nxt = in_now;
          cnt_nxt = '0;
          if (in_tuser == CMD_TICK) begin
            cap_ok_nxt = 1'b0;
            state_nxt  = S_TICK;
          end else if (32'(in_ph) < NUM_PHASES) begin
            cap_ok_nxt = 1'b1;
            x_nxt      = {in_cap - prev_cap_r[in_idx], 8'b0};
            f_nxt      = filt_r[in_idx];
            ema_nxt    = EMA_W'(alpha_sat);
            bm_nxt     = ALPHA_ONE - alpha_sat;
            state_nxt  = S_EMA;
          end else begin
            cap_ok_nxt = 1'b0;
            state_nxt  = S_FIN;
          end
        end
      end
      S_EMA: begin
        ema_nxt = ema_step;
        bm_nxt  = bm_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ALPHA_W-1)) begin
          nf_nxt        = ema_step[PER_W+ALPHA_W-2:ALPHA_W-1];
          filt_nxt[idx] = ema_step[PER_W+ALPHA_W-2:ALPHA_W-1];
          pz_nxt        = PROD_W'(phasing_r);
          pp_nxt        = PROD_W'(pulse_r);
          cnt_nxt       = '0;
          state_nxt     = S_ANG;
        end
      end
      S_ANG: begin
        pz_nxt  = pz_step;
        pp_nxt  = pp_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ANGLE_W-1)) begin
          qz_nxt    = pz_step[PROD_W-1:DIV_SH];
          qp_nxt    = pp_step[PROD_W-1:DIV_SH];
          rz_nxt    = '0;
          rp_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rz_nxt  = rz_ge ? REM_W'(rz_t - (REM_W+1)'(DIV_K)) : REM_W'(rz_t);
        rp_nxt  = rp_ge ? REM_W'(rp_t - (REM_W+1)'(DIV_K)) : REM_W'(rp_t);
        qz_nxt  = {qz_r[DIVD_W-2:0], rz_ge};
        qp_nxt  = {qp_r[DIVD_W-2:0], rp_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVD_W-1)) begin
          // capture done: commit the phase state
          prev_cap_nxt[idx] = cap_r;
          seen_nxt[idx]     = now_r;
          lost_nxt[idx]     = 1'b0;
          state_nxt         = S_FIN;
        end
      end
      S_TICK: begin
        // every phase silent past the timeout is lost
        for (int i = 0; i < NUM_PHASES; i++) begin
          if ((now_r - seen_r[i]) > TS_W'(timeout_r)) begin
            lost_nxt[i] = 1'b1;
          end
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (cap_ok_r) begin
            out_data_nxt = {3'b0, lost_ext[LOSS_W-1:0], pulse_ticks, zero_time,
                            nf_r, ph_r};
          end else begin
            out_data_nxt = {3'b0, lost_ext[LOSS_W-1:0],
                            (OUT_DATA_W-3-LOSS_W)'(0)};
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control, configuration and per-phase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
      alpha_r     <= ALPHA_RST;
      phasing_r   <= PHASING_RST;
      pulse_r     <= PULSE_RST;
      timeout_r   <= TIMEOUT_RST;
      lost_r      <= '0;
      for (int i = 0; i < NUM_PHASES; i++) begin
        prev_cap_r[i] <= '0;
        filt_r[i]     <= '0;
        seen_r[i]     <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cap_ok_r    <= cap_ok_nxt;
      out_valid_r <= out_valid_nxt;
      lost_r      <= lost_nxt;
      prev_cap_r  <= prev_cap_nxt;
      filt_r      <= filt_nxt;
      seen_r      <= seen_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_EMA_ALPHA:     alpha_r   <= cfg_wdata[ALPHA_W-1:0];
          REG_PHASING_ANGLE: phasing_r <= cfg_wdata[ANGLE_W-1:0];
          REG_PULSE_ANGLE:   pulse_r   <= cfg_wdata[ANGLE_W-1:0];
          REG_LOSS_TIMEOUT:  timeout_r <= cfg_wdata[TMO_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ph_r       <= ph_nxt;
    cap_r      <= cap_nxt;
    now_r      <= now_nxt;
    x_r        <= x_nxt;
    f_r        <= f_nxt;
    bm_r       <= bm_nxt;
    ema_r      <= ema_nxt;
    nf_r       <= nf_nxt;
    pz_r       <= pz_nxt;
    pp_r       <= pp_nxt;
    qz_r       <= qz_nxt;
    qp_r       <= qp_nxt;
    rz_r       <= rz_nxt;
    rp_r       <= rp_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- verif/phase_period_tracker_watchdog_tb.sv -----
// self-checking testbench for the three-phase period tracker and loss watchdog
`timescale 1ns / 1ps

module phase_period_tracker_watchdog_tb;
  import ptw_pkg::*;

  localparam int NPH          = 3;
  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 80;      // longer than a capture's full pass through the block
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_ITEMS   = 165;
  localparam logic [PH_SEL_W-1:0] PH_NONE = 2'd3;   // phase code with no phase behind it
  localparam logic [63:0] ANGLE_DIV = 64'd1474560;  // 5760 * 256
  localparam logic [63:0] Q16_ONE   = 64'd65536;

  typedef struct packed {
    logic [PH_SEL_W-1:0] phase;
    logic [PER_W-1:0]    period;
    logic [TS_W-1:0]     zero_time;
    logic [TS_W-1:0]     pulse;
    logic [LOSS_W-1:0]   loss;
  } tracker_result_t;

  // dut ports, inputs all known from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // phase_select, capture_time, now_ms
  logic                  in_tuser   = 1'b0; // command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // result_phase, period_avg, zero_time, pulse_ticks,
                                     // loss_flags
  logic                  cfg_we     = 1'b0;
  logic [CFG_A_W-1:0]    cfg_addr   = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  // testbench copy of the registers and the per-phase state
  logic [ALPHA_W-1:0] alpha_cfg;
  logic [ANGLE_W-1:0] phasing_cfg;
  logic [ANGLE_W-1:0] pulse_cfg;
  logic [TMO_W-1:0]   timeout_cfg;
  logic [TS_W-1:0]    cap_hist   [NPH];
  logic [PER_W-1:0]   period_q8  [NPH];
  logic [TS_W-1:0]    seen_ms    [NPH];
  logic               lost_q     [NPH];

  // stimulus generator state
  logic [TS_W-1:0] gen_cap  [NPH];
  logic [TS_W-1:0] gen_base [NPH];
  logic [TS_W-1:0] gen_ms;

  tracker_result_t expected_results[$];
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_rx       = 1'b0;
  logic in_xfer      = 1'b0;
  int  cycles        = 0;
  int  errors        = 0;
  int  n_captures    = 0;
  int  n_ticks       = 0;
  int  n_checked     = 0;
  int  n_writes      = 0;

  phase_period_tracker_watchdog #(.NUM_PHASES(NPH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("** phase_period_tracker_watchdog: FAILED **");
      $finish;
    end
  end

  // receiver readiness, with an optional long hold-off
  always @(negedge clk) begin
    out_tready <= hold_rx ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // reset the tracker copy to its power-up state
  task automatic reset_tracker_copy();
    alpha_cfg   = ALPHA_RST;
    phasing_cfg = PHASING_RST;
    pulse_cfg   = PULSE_RST;
    timeout_cfg = TIMEOUT_RST;
    for (int i = 0; i < NPH; i++) begin
      cap_hist[i]  = '0;
      period_q8[i] = '0;
      seen_ms[i]   = '0;
      lost_q[i]    = 1'b0;
      gen_cap[i]   = '0;
      gen_base[i]  = 32'd20000 + $urandom_range(0, 400);
    end
    gen_ms = '0;
  endtask

  // expected result of one item, advancing the tracker copy
  function automatic tracker_result_t track_item(input logic cmd,
                                                 input logic [PH_SEL_W-1:0] ph,
                                                 input logic [TS_W-1:0] cap,
                                                 input logic [TS_W-1:0] now);
    tracker_result_t r;
    logic [63:0] a, acc, nf, shift, width;
    logic [TS_W-1:0] raw, silent;
    r = '0;
    if (cmd == CMD_TICK) begin
      // watchdog: strictly longer silence than the timeout marks a phase lost
      for (int i = 0; i < NPH; i++) begin
        silent = now - seen_ms[i];
        if (silent > {16'b0, timeout_cfg}) lost_q[i] = 1'b1;
      end
    end else if (ph < NPH) begin
      // ema of the wrapped period, weight clamped to one
      a     = (alpha_cfg > ALPHA_ONE) ? Q16_ONE : 64'(alpha_cfg);
      raw   = cap - cap_hist[ph];
      acc   = (64'(raw) << 8) * a + 64'(period_q8[ph]) * (Q16_ONE - a);
      nf    = (acc >> 16) & 64'hFF_FFFF_FFFF;
      shift = (nf * 64'(phasing_cfg)) / ANGLE_DIV;
      width = (nf * 64'(pulse_cfg)) / ANGLE_DIV;
      cap_hist[ph]  = cap;
      period_q8[ph] = nf[PER_W-1:0];
      seen_ms[ph]   = now;
      lost_q[ph]    = 1'b0;
      r.phase     = ph;
      r.period    = nf[PER_W-1:0];
      r.zero_time = cap + shift[TS_W-1:0];
      r.pulse     = (width > 64'hFFFF_FFFF) ? '1 : width[TS_W-1:0];
    end
    for (int i = 0; i < LOSS_W; i++) r.loss[i] = (i < NPH) ? lost_q[i] : 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch on %s at cycle %0d: got %0h, expected %0h", what, cycles, got, want);
  endtask

  // result checking and prediction at each rising edge
  always @(posedge clk) begin
    tracker_result_t want;
    tracker_result_t got;
    in_xfer <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.phase     = out_tdata[1:0];
      got.period    = out_tdata[41:2];
      got.zero_time = out_tdata[73:42];
      got.pulse     = out_tdata[105:74];
      got.loss      = out_tdata[108:106];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(got.period), 64'h0);
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (got.phase !== want.phase)
          report_mismatch("result_phase", 64'(got.phase), 64'(want.phase));
        if (got.period !== want.period)
          report_mismatch("period_avg", 64'(got.period), 64'(want.period));
        if (got.zero_time !== want.zero_time)
          report_mismatch("zero_time", 64'(got.zero_time), 64'(want.zero_time));
        if (got.pulse !== want.pulse)
          report_mismatch("pulse_ticks", 64'(got.pulse), 64'(want.pulse));
        if (got.loss !== want.loss)
          report_mismatch("loss_flags", 64'(got.loss), 64'(want.loss));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == CMD_TICK) n_ticks++;
      else n_captures++;
      expected_results.push_back(track_item(in_tuser, in_tdata[1:0], in_tdata[33:2],
                                             in_tdata[65:34]));
    end
  end

  // offer one item and wait for its transfer
  task automatic send_item(input logic cmd, input logic [PH_SEL_W-1:0] ph,
                           input logic [TS_W-1:0] cap, input logic [TS_W-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, now, cap, ph};
    do @(negedge clk); while (!in_xfer);
  endtask

  // drop valid, wait for every result and let the block go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] val);
    // stop offering and wait until every item has left the block
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_writes++;
    case (idx)
      REG_EMA_ALPHA:     alpha_cfg   = val[ALPHA_W-1:0];
      REG_PHASING_ANGLE: phasing_cfg = val[ANGLE_W-1:0];
      REG_PULSE_ANGLE:   pulse_cfg   = val[ANGLE_W-1:0];
      REG_LOSS_TIMEOUT:  timeout_cfg = val[TMO_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_W-1:0] pick_setting(input int lo, input int hi);
    case ($urandom_range(0, 3))
      0:       return CFG_W'(lo);
      1:       return CFG_W'(hi);
      default: return CFG_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // random register set, extremes included
  task automatic random_settings();
    logic [CFG_W-1:0] v;
    v = pick_setting(0, 65536);
    if ($urandom_range(0, 9) == 0) v = '1;
    write_reg(REG_EMA_ALPHA, v);
    v = pick_setting(0, 5760);
    if ($urandom_range(0, 9) == 0) v = CFG_W'(8191);
    write_reg(REG_PHASING_ANGLE, v);
    v = pick_setting(0, 5760);
    if ($urandom_range(0, 9) == 0) v = CFG_W'(8191);
    write_reg(REG_PULSE_ANGLE, v);
    v = ($urandom_range(0, 3) == 0) ? pick_setting(0, 65535) : CFG_W'($urandom_range(0, 80));
    write_reg(REG_LOSS_TIMEOUT, v);
  endtask

  // mostly mains-like capture trains and ticks, some noise and stray phases
  task automatic send_random_item();
    int sel;
    logic [PH_SEL_W-1:0] ph;
    logic [TS_W-1:0] per;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      ph  = PH_SEL_W'($urandom_range(0, NPH - 1));
      per = gen_base[ph] + $urandom_range(0, 2000) - 1000;
      if ($urandom_range(0, 19) == 0) per = $urandom;
      gen_cap[ph] = gen_cap[ph] + per;
      gen_ms      = gen_ms + $urandom_range(0, 20);
      send_item(CMD_CAPTURE, ph, gen_cap[ph], gen_ms);
    end else if (sel < 85) begin
      gen_ms = gen_ms + $urandom_range(0, 8);
      send_item(CMD_TICK, PH_SEL_W'($urandom_range(0, 3)), $urandom, gen_ms);
    end else if (sel < 95) begin
      send_item(1'($urandom_range(0, 1)), PH_SEL_W'($urandom_range(0, 3)), $urandom, $urandom);
    end else begin
      send_item(CMD_CAPTURE, PH_NONE, $urandom, $urandom);
    end
  endtask

  // reset values, first captures, wrapping periods and the timeout boundary
  task automatic test_reset_defaults();
    send_idle_pct = 20;
    recv_idle_pct = 30;
    send_item(CMD_CAPTURE, 2'd0, 32'd1000, 32'd5);
    send_item(CMD_CAPTURE, 2'd0, 32'd21000, 32'd25);
    send_item(CMD_CAPTURE, 2'd1, 32'hFFFF_FFFF, 32'd30);
    send_item(CMD_CAPTURE, 2'd2, 32'd0, 32'd30);
    send_item(CMD_CAPTURE, PH_NONE, $urandom, $urandom);
    send_item(CMD_TICK, 2'd0, 32'd0, 32'd70);
    send_item(CMD_TICK, 2'd3, 32'hFFFF_FFFF, 32'd71);
    send_item(CMD_CAPTURE, 2'd1, 32'd5, 32'd72);
    send_item(CMD_TICK, 2'd0, 32'd0, 32'd0);
    settle();
  endtask

  // ema weight above one, exactly one and zero, with the largest period
  task automatic test_alpha_extremes();
    write_reg(REG_EMA_ALPHA, '1);
    write_reg(REG_PHASING_ANGLE, CFG_W'(5760));
    write_reg(REG_PULSE_ANGLE, CFG_W'(5760));
    send_item(CMD_CAPTURE, 2'd0, 32'hFFFF_FFFF, 32'd100);
    send_item(CMD_CAPTURE, 2'd0, 32'hFFFF_FFFE, 32'd101);
    write_reg(REG_EMA_ALPHA, CFG_W'(65536));
    send_item(CMD_CAPTURE, 2'd2, 32'h8000_0000, 32'd102);
    write_reg(REG_EMA_ALPHA, CFG_W'(0));
    send_item(CMD_CAPTURE, 2'd0, 32'd12345, 32'd103);
    settle();
  endtask

  // wide phasing angle and pulse saturation, then zero angles
  task automatic test_angle_extremes();
    write_reg(REG_EMA_ALPHA, CFG_W'(65536));
    write_reg(REG_PHASING_ANGLE, CFG_W'(8191));
    write_reg(REG_PULSE_ANGLE, CFG_W'(8191));
    send_item(CMD_CAPTURE, 2'd1, 32'hFFFF_FFF0, 32'd200);
    send_item(CMD_CAPTURE, 2'd1, 32'hFFFF_FFEF, 32'd201);
    write_reg(REG_PHASING_ANGLE, CFG_W'(0));
    write_reg(REG_PULSE_ANGLE, CFG_W'(0));
    send_item(CMD_CAPTURE, 2'd2, 32'h1234_5678, 32'd202);
    settle();
  endtask

  // timeout of zero and of its largest value, both sides of the compare
  task automatic test_watchdog();
    write_reg(REG_LOSS_TIMEOUT, CFG_W'(0));
    send_item(CMD_CAPTURE, 2'd0, 32'd5000, 32'd300);
    send_item(CMD_TICK, 2'd0, 32'd0, 32'd300);
    send_item(CMD_TICK, 2'd0, 32'd0, 32'd301);
    write_reg(REG_LOSS_TIMEOUT, CFG_W'(65535));
    send_item(CMD_CAPTURE, 2'd0, 32'd25000, 32'd1000);
    send_item(CMD_CAPTURE, 2'd1, 32'd25000, 32'd1000);
    send_item(CMD_CAPTURE, 2'd2, 32'd25000, 32'd1000);
    send_item(CMD_TICK, 2'd0, 32'd0, 32'd66535);
    send_item(CMD_TICK, 2'd0, 32'd0, 32'd66536);
    settle();
  endtask

  // random traffic under one idle profile and one random register set
  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    random_settings();
    for (int i = 0; i < NPH; i++) gen_cap[i] = cap_hist[i];
    gen_ms        = seen_ms[0];
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    repeat (RAND_ITEMS) send_random_item();
    settle();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      repeat (12) send_random_item();
    join
    settle();
  endtask

  initial begin
    reset_tracker_copy();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_alpha_extremes();
    test_angle_extremes();
    test_watchdog();
    test_random_traffic(27, 69);
    test_random_traffic(69, 27);
    test_random_traffic(0, 0);
    test_backpressure();

    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 64'(expected_results.size()), 64'h0);
    $display("run: %0d captures and %0d watchdog ticks, %0d results compared, %0d mismatches",
             n_captures, n_ticks, n_checked, errors);
    $display("run: %0d register writes, three idle profiles and one long output hold-off",
             n_writes);
    if (errors == 0) begin
      $display("** phase_period_tracker_watchdog: PASSED **");
    end else begin
      $display("** phase_period_tracker_watchdog: FAILED **");
    end
    $finish;
  end

endmodule

// ----- phase_period_tracker_watchdog.f -----
hdl/ptw_pkg.sv
hdl/phase_period_tracker_watchdog.sv
verif/phase_period_tracker_watchdog_tb.sv
